[rtl/modular_square_root_assert.svh]
// assertion macros for the modular square root checker
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH

// a holds at an edge, so b holds at the same edge
`define MSR_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("modular square root check failed");

// a holds at an edge, so b holds at the next edge
`define MSR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("modular square root check failed");

`endif

[rtl/msr_pkg.sv]
// shared constants for the modular square root block
package msr_pkg;
    localparam int MSR_MOD_BITS = 31;
    localparam int MSR_ZLIMIT   = 4096;
    localparam int MSR_ZW       = 13;
endpackage

[rtl/msr_if.sv]
// valid/ready channels for the modular square root block
interface msr_in_if
    import msr_pkg::*;
#(
    parameter int W = MSR_MOD_BITS
);
    logic         valid;
    logic         ready;
    logic [W-1:0] value_in;
    logic [W-1:0] prime_mod;

    modport source (output valid, output value_in, output prime_mod, input ready);
    modport sink   (input valid, input value_in, input prime_mod, output ready);
endinterface

interface msr_out_if
    import msr_pkg::*;
#(
    parameter int W = MSR_MOD_BITS
);
    logic         valid;
    logic         ready;
    logic [W-1:0] root_out;
    logic         no_root;

    modport source (output valid, output root_out, output no_root, input ready);
    modport sink   (input valid, input root_out, input no_root, output ready);
endinterface

[rtl/modular_square_root.sv]
// modular square root (tonelli-shanks) over one shared shift-add modular multiplier
// One word at a time: the input is taken only when the block is idle, and the result
// word is held on the output until taken. Every modular product is formed bit-serially
// by one add-compare-subtract unit in state S_MUL, after a set-up state. Each exponent
// bit costs one squaring, plus one further product when it is set. Moduli of 2 or below
// are answered without any product, and a modulus of 3 mod 4 needs only the Euler test
// and one further exponentiation. Other moduli need several exponentiations, one for each
// candidate non-residue, plus about s^2 products, where 2^s is the power of two in p-1.
// A composite modulus can run the non-residue search up to its limit, candidates 2 to 4095
// (below MSR_ZLIMIT = 4096). The input reduction of the value uses the same unit.
module modular_square_root
    import msr_pkg::*;
#(
    parameter int MOD_BITS = MSR_MOD_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msr_in_if.sink    i_in,
    msr_out_if.source o_out
);
    localparam int W  = MOD_BITS;
    localparam int CW = $clog2(W);
    localparam int SW = $clog2(W) + 1;

    localparam logic [4:0] S_IDLE = 5'd0,  S_MUL  = 5'd1,  S_PTOP = 5'd2,  S_PMR  = 5'd3;
    localparam logic [4:0] S_PSQ  = 5'd4,  S_PSQR = 5'd5,  S_RDN  = 5'd6,  S_EUL  = 5'd7;
    localparam logic [4:0] S_R34  = 5'd8,  S_QS   = 5'd9,  S_ZT   = 5'd10, S_ZC   = 5'd11;
    localparam logic [4:0] S_SC   = 5'd12, S_ST   = 5'd13, S_SR   = 5'd14, S_LOOP = 5'd15;
    localparam logic [4:0] S_SQ   = 5'd16, S_SQR  = 5'd17, S_SB   = 5'd18, S_SBR  = 5'd19;
    localparam logic [4:0] S_SCC  = 5'd20, S_STT  = 5'd21, S_SRR  = 5'd22, S_OUT  = 5'd23;

    logic [4:0]        r_state, n_state, r_mret, n_mret, r_pret, n_pret;
    logic              r_red, n_red;
    logic [CW-1:0]     r_mcnt, n_mcnt;
    logic [W-1:0]      r_acc, n_acc, r_ma, n_ma, r_mb, n_mb;
    logic [W-1:0]      r_pr, n_pr, r_pb, n_pb, r_pe, n_pe;
    logic [W-1:0]      r_n, n_n, r_p, n_p, r_q, n_q;
    logic [W-1:0]      r_c, n_c, r_t, n_t, r_r, n_r, r_sq, n_sq, r_b, n_b;
    logic [SW-1:0]     r_s, n_s, r_mm, n_mm, r_i, n_i, r_j, n_j;
    logic [MSR_ZW-1:0] r_z, n_z;
    logic [W-1:0]      r_root, n_root;
    logic              r_flag, n_flag;

    logic [W:0]   t1, t1r, t2, t2r, pe1, qe1;
    logic [W-1:0] pm1, half, pp1q, qh;
    logic         in_bit, add_bit;

    // shared add-compare-subtract unit, and the exponent constants derived from p and q
    always_comb begin
        in_bit  = r_red & r_mb[W-1];
        add_bit = ~r_red & r_mb[W-1];
        t1      = {r_acc, in_bit};
        t1r     = (t1 >= {1'b0, r_p}) ? t1 - {1'b0, r_p} : t1;
        t2      = t1r + (add_bit ? {1'b0, r_ma} : '0);
        t2r     = (t2 >= {1'b0, r_p}) ? t2 - {1'b0, r_p} : t2;
        pm1     = r_p - W'(1);
        half    = pm1 >> 1;
        pe1     = {1'b0, r_p} + (W+1)'(1);
        pp1q    = W'(pe1 >> 2);
        qe1     = {1'b0, r_q} + (W+1)'(1);
        qh      = W'(qe1 >> 1);
    end

    always_comb begin
        n_state = r_state; n_mret = r_mret; n_pret = r_pret; n_red = r_red;
        n_mcnt = r_mcnt; n_acc = r_acc; n_ma = r_ma; n_mb = r_mb;
        n_pr = r_pr; n_pb = r_pb; n_pe = r_pe; n_n = r_n; n_p = r_p; n_q = r_q;
        n_c = r_c; n_t = r_t; n_r = r_r; n_sq = r_sq; n_b = r_b;
        n_s = r_s; n_mm = r_mm; n_i = r_i; n_j = r_j; n_z = r_z;
        n_root = r_root; n_flag = r_flag;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_n = i_in.value_in;
                    n_p = i_in.prime_mod;
                    n_root = '0;
                    n_flag = 1'b0;
                    if (i_in.prime_mod < W'(2)) begin
                        n_state = S_OUT;
                    end else if (i_in.prime_mod == W'(2)) begin
                        n_root = W'(i_in.value_in[0]);
                        n_state = S_OUT;
                    end else begin
                        n_ma = '0; n_mb = i_in.value_in; n_red = 1'b1;
                        n_acc = '0; n_mcnt = CW'(W-1); n_mret = S_RDN; n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_acc = t2r[W-1:0];
                n_mb = r_mb << 1;
                n_mcnt = r_mcnt - CW'(1);
                if (r_mcnt == '0) n_state = r_mret;
            end
            S_PTOP: begin
                if (r_pe == '0) begin
                    n_state = r_pret;
                end else if (r_pe[0]) begin
                    n_ma = r_pr; n_mb = r_pb; n_red = 1'b0;
                    n_acc = '0; n_mcnt = CW'(W-1); n_mret = S_PMR; n_state = S_MUL;
                end else begin
                    n_state = S_PSQ;
                end
            end
            S_PMR: begin
                n_pr = r_acc;
                n_state = S_PSQ;
            end
            S_PSQ: begin
                n_ma = r_pb; n_mb = r_pb; n_red = 1'b0;
                n_acc = '0; n_mcnt = CW'(W-1); n_mret = S_PSQR; n_state = S_MUL;
            end
            S_PSQR: begin
                n_pb = r_acc;
                n_pe = r_pe >> 1;
                n_state = S_PTOP;
            end
            S_RDN: begin
                n_n = r_acc;
                if (r_acc == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_pr = W'(1); n_pb = r_acc; n_pe = half; n_pret = S_EUL; n_state = S_PTOP;
                end
            end
            S_EUL: begin
                if (r_pr != W'(1)) begin
                    n_flag = 1'b1;
                    n_state = S_OUT;
                end else if (r_p[1:0] == 2'b11) begin
                    n_pr = W'(1); n_pb = r_n; n_pe = pp1q; n_pret = S_R34; n_state = S_PTOP;
                end else begin
                    n_q = pm1;
                    n_s = '0;
                    n_state = S_QS;
                end
            end
            S_R34: begin
                n_root = r_pr;
                n_state = S_OUT;
            end
            S_QS: begin
                if (!r_q[0]) begin
                    n_q = r_q >> 1;
                    n_s = r_s + SW'(1);
                end else begin
                    n_z = MSR_ZW'(2);
                    n_state = S_ZT;
                end
            end
            S_ZT: begin
                if (64'(r_z) >= 64'(r_p) || 64'(r_z) >= 64'(MSR_ZLIMIT)) begin
                    n_flag = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_pr = W'(1); n_pb = W'(r_z); n_pe = half; n_pret = S_ZC;
                    n_state = S_PTOP;
                end
            end
            S_ZC: begin
                if (r_pr == pm1) begin
                    n_mm = r_s;
                    n_pr = W'(1); n_pb = W'(r_z); n_pe = r_q; n_pret = S_SC; n_state = S_PTOP;
                end else begin
                    n_z = r_z + MSR_ZW'(1);
                    n_state = S_ZT;
                end
            end
            S_SC: begin
                n_c = r_pr;
                n_pr = W'(1); n_pb = r_n; n_pe = r_q; n_pret = S_ST; n_state = S_PTOP;
            end
            S_ST: begin
                n_t = r_pr;
                n_pr = W'(1); n_pb = r_n; n_pe = qh; n_pret = S_SR; n_state = S_PTOP;
            end
            S_SR: begin
                n_r = r_pr;
                n_state = S_LOOP;
            end
            S_LOOP: begin
                if (r_t == W'(1)) begin
                    n_root = r_r;
                    n_state = S_OUT;
                end else begin
                    n_i = '0;
                    n_sq = r_t;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                if (r_sq != W'(1) && r_i < r_mm) begin
                    n_ma = r_sq; n_mb = r_sq; n_red = 1'b0;
                    n_acc = '0; n_mcnt = CW'(W-1); n_mret = S_SQR; n_state = S_MUL;
                end else if (r_sq != W'(1) || r_i >= r_mm) begin
                    n_flag = 1'b1;
                    n_state = S_OUT;
                end else begin
                    n_b = r_c;
                    n_j = '0;
                    n_state = S_SB;
                end
            end
            S_SQR: begin
                n_sq = r_acc;
                n_i = r_i + SW'(1);
                n_state = S_SQ;
            end
            S_SB: begin
                n_ma = r_b; n_mb = r_b; n_red = 1'b0; n_acc = '0; n_mcnt = CW'(W-1);
                n_state = S_MUL;
                if (({1'b0, r_j} + {1'b0, r_i} + (SW+1)'(1)) < {1'b0, r_mm}) begin
                    n_mret = S_SBR;
                end else begin
                    n_mm = r_i;
                    n_mret = S_SCC;
                end
            end
            S_SBR: begin
                n_b = r_acc;
                n_j = r_j + SW'(1);
                n_state = S_SB;
            end
            S_SCC: begin
                n_c = r_acc;
                n_ma = r_t; n_mb = r_acc; n_red = 1'b0;
                n_acc = '0; n_mcnt = CW'(W-1); n_mret = S_STT; n_state = S_MUL;
            end
            S_STT: begin
                n_t = r_acc;
                n_ma = r_r; n_mb = r_b; n_red = 1'b0;
                n_acc = '0; n_mcnt = CW'(W-1); n_mret = S_SRR; n_state = S_MUL;
            end
            S_SRR: begin
                n_r = r_acc;
                n_state = S_LOOP;
            end
            S_OUT: begin
                if (o_out.ready) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mret  <= S_IDLE;
            r_pret  <= S_IDLE;
            r_red   <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_mret  <= n_mret;
            r_pret  <= n_pret;
            r_red   <= n_red;
            r_mcnt  <= n_mcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc; r_ma <= n_ma; r_mb <= n_mb;
        r_pr <= n_pr; r_pb <= n_pb; r_pe <= n_pe;
        r_n <= n_n; r_p <= n_p; r_q <= n_q;
        r_c <= n_c; r_t <= n_t; r_r <= n_r; r_sq <= n_sq; r_b <= n_b;
        r_s <= n_s; r_mm <= n_mm; r_i <= n_i; r_j <= n_j; r_z <= n_z;
        r_root <= n_root; r_flag <= n_flag;
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = (r_state == S_OUT);
    assign o_out.root_out = r_root;
    assign o_out.no_root  = r_flag;
endmodule

[rtl/msr_check.sv]
// port checker for the modular square root block
`include "modular_square_root_assert.svh"

module msr_check
    import msr_pkg::*;
#(
    parameter int W = MSR_MOD_BITS
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] root_out,
    input logic         no_root
);
    `MSR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `MSR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(root_out))
    `MSR_ASSERT_SAME(a_one_word, clk, rst_n, out_valid, !in_ready)
    `MSR_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `MSR_ASSERT_SAME(a_flag_zero_root, clk, rst_n, out_valid && no_root, root_out == '0)
endmodule

bind modular_square_root msr_check #(.W(MOD_BITS)) u_msr_check (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .root_out  (o_out.root_out),
    .no_root   (o_out.no_root)
);

[verif/modular_square_root_checker.sv]
// checker for the modular square root block: watches both channels, predicts and compares
module modular_square_root_checker
    import msr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    msr_in_if.sink    i_in_mon,
    msr_out_if.sink   i_out_mon,
    output int        o_errors,
    output int        o_pending,
    output int        o_results
);
    typedef struct packed {
        logic [MSR_MOD_BITS-1:0] root;
        logic                    nr;
    } t_root_word;

    t_root_word expected_roots[$];
    int         mismatches;

    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
        return (a * b) % m;
    endfunction

    function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                               longint unsigned m);
        longint unsigned r;
        r = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) r = mulmod(r, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic t_root_word predict_root(longint unsigned n, longint unsigned p);
        t_root_word      w;
        longint unsigned q, s, z, mm, c, t, r, i, sq, b;
        bit              done;
        w = '0;
        if (p < 2) return w;
        if (p == 2) begin
            w.root = MSR_MOD_BITS'(n & 1);
            return w;
        end
        n = n % p;
        if (n == 0) return w;
        if (powmod(n, (p - 1) / 2, p) != 1) begin
            w.nr = 1'b1;
            return w;
        end
        if ((p & 3) == 3) begin
            w.root = MSR_MOD_BITS'(powmod(n, (p + 1) / 4, p));
            return w;
        end
        q = p - 1;
        s = 0;
        while (q[0] == 1'b0) begin
            q = q >> 1;
            s++;
        end
        z = 2;
        while (z < p && z < MSR_ZLIMIT && powmod(z, (p - 1) / 2, p) != p - 1) z++;
        if (z >= p || z >= MSR_ZLIMIT) begin
            w.nr = 1'b1;
            return w;
        end
        mm = s;
        c = powmod(z, q, p);
        t = powmod(n, q, p);
        r = powmod(n, (q + 1) / 2, p);
        done = 1'b0;
        while (!done) begin
            if (t == 1) begin
                w.root = MSR_MOD_BITS'(r);
                done = 1'b1;
            end else begin
                i = 0;
                sq = t;
                while (sq != 1 && i < mm) begin
                    sq = mulmod(sq, sq, p);
                    i++;
                end
                if (sq != 1 || i >= mm) begin
                    w.nr = 1'b1;
                    done = 1'b1;
                end else begin
                    b = c;
                    for (longint unsigned j = 0; j + i + 1 < mm; j++) b = mulmod(b, b, p);
                    mm = i;
                    c = mulmod(b, b, p);
                    t = mulmod(t, c, p);
                    r = mulmod(r, b, p);
                end
            end
        end
        return w;
    endfunction

    assign o_errors  = mismatches;
    assign o_pending = expected_roots.size();

    always @(posedge i_clk) begin
        t_root_word want;
        if (!i_rst_n) begin
            mismatches <= 0;
            o_results  <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                expected_roots = {expected_roots,
                                  predict_root(64'(i_in_mon.value_in),
                                               64'(i_in_mon.prime_mod))};
            if (i_out_mon.valid && i_out_mon.ready) begin
                o_results <= o_results + 1;
                if (expected_roots.size() == 0) begin
                    if (mismatches < 10) $display("unexpected word: root %0d no_root %0b",
                                                  i_out_mon.root_out, i_out_mon.no_root);
                    mismatches <= mismatches + 1;
                end else begin
                    want = expected_roots.pop_front();
                    if (want.root !== i_out_mon.root_out || want.nr !== i_out_mon.no_root) begin
                        if (mismatches < 10)
                            $display("mismatch: root exp %0d got %0d, no_root exp %0b got %0b",
                                     want.root, i_out_mon.root_out, want.nr, i_out_mon.no_root);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end
endmodule

[verif/modular_square_root_tb.sv]
// testbench top for the modular square root block: stimulus, idling and verdict
module modular_square_root_tb;
    import msr_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors, pending, results;
    int   src_idle_pct, snk_idle_pct;
    bit   hold_off;
    int   sent;

    msr_in_if  in_ch();
    msr_out_if out_ch();

    modular_square_root u_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink),
                               .o_out(out_ch.source));

    modular_square_root_checker u_chk (.i_clk(i_clk), .i_rst_n(i_rst_n),
                                       .i_in_mon(in_ch.sink), .i_out_mon(out_ch.sink),
                                       .o_errors(errors), .o_pending(pending),
                                       .o_results(results));

    // odd primes of both residues mod 4, small and near the top of the range
    localparam int NPRIMES = 16;
    logic [30:0] primes [NPRIMES] = '{31'd3, 31'd5, 31'd7, 31'd13, 31'd17, 31'd41, 31'd97,
        31'd257, 31'd65537, 31'd7681, 31'd12289, 31'd40961, 31'd998244353,
        31'd2147483647, 31'd2147483629, 31'd1073741789};

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle_pct);
    end

    // valid stays up after a take unless the sender idles or drains
    task automatic send_word(input logic [30:0] n, input logic [30:0] p);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.value_in  <= n;
        in_ch.prime_mod <= p;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
    endtask

    task automatic send_random;
        logic [30:0] p, x;
        int k;
        k = $urandom_range(9);
        p = primes[$urandom_range(NPRIMES - 1)];
        x = 31'($urandom());
        if (k == 0) send_word(x, 31'($urandom()));
        else if (k < 6) send_word(31'((longint'(x) * x) % p), p);
        else send_word(x, p);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        #2000000000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        in_ch.valid     <= 1'b0;
        in_ch.value_in  <= '0;
        in_ch.prime_mod <= '0;
        i_rst_n         <= 1'b0;
        hold_off        = 1'b0;
        src_idle_pct    = 35;
        snk_idle_pct    = 87;
        sent            = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(31'd0, 31'd0);
        send_word(31'h7fffffff, 31'd1);
        send_word(31'h7fffffff, 31'd2);
        send_word(31'd6, 31'd2);
        send_word(31'h7fffffff, 31'h7fffffff);
        send_word(31'h7ffffffe, 31'h7fffffff);
        send_word(31'd4, 31'd7);
        send_word(31'd3, 31'd7);
        send_word(31'd2, 31'd17);
        send_word(31'd3, 31'd17);
        send_word(31'd16, 31'd97);
        send_word(31'd5, 31'd65537);
        send_word(31'd3, 31'd65537);
        send_word(31'd2, 31'd998244353);
        send_word(31'd10, 31'd15);
        send_word(31'd4, 31'd21);
        send_word(31'd9, 31'd8);
        send_word(31'h55555555, 31'h2aaaaaab);
        send_word(31'h2aaaaaaa, 31'h55555555);
        drain();

        // long receiver hold-off while words keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (4) send_random();
        join
        drain();

        repeat (30) send_random();
        drain();
        src_idle_pct = 87;
        snk_idle_pct = 35;
        repeat (30) send_random();
        drain();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        repeat (17) send_random();
        drain();
        repeat (50) @(posedge i_clk);

        $display("sent %0d words, checked %0d roots over moduli 0, 1, 2, 3 and 1 mod 4",
                 sent, results);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
